// ----- sv/spi_nor_flash_slave_model_defines.svh -----
// Assertion macros for the SPI NOR flash slave model.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SPI_NOR_FLASH_SLAVE_MODEL_DEFINES_SVH
`define SPI_NOR_FLASH_SLAVE_MODEL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SNFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/snfs_pkg.sv -----
// Shared types and constants of the SPI NOR flash slave model.
// No dependencies; imported by the front end, queue, back end and top level.
package snfs_pkg;

    // Flash opcodes.
    localparam logic [7:0] OPC_READ_ID      = 8'h9F;
    localparam logic [7:0] OPC_READ_STATUS  = 8'h05;
    localparam logic [7:0] OPC_CHIP_ERASE   = 8'hC7;
    localparam logic [7:0] OPC_READ         = 8'h03;
    localparam logic [7:0] OPC_PAGE_PROGRAM = 8'h02;

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] STATUS_BYTE = 8'h00;

    localparam logic [23:0] CHIP_ID_RESET = 24'hEF4018;

    // Configuration port.
    localparam int   PADDR_W         = 3;
    localparam logic CFG_IDX_CHIP_ID = 1'b0;

    // Work kinds passed from the front end to the back end.
    localparam logic [1:0] OP_KIND_CONST = 2'd0;
    localparam logic [1:0] OP_KIND_READ  = 2'd1;
    localparam logic [1:0] OP_KIND_WRITE = 2'd2;
    localparam logic [1:0] OP_KIND_ERASE = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] addr;
        logic [7:0]  data;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- sv/snfs_front.sv -----
// Front end of the SPI NOR flash slave model: command decode and transaction state.
// Depends on snfs_pkg; produces one t_op per accepted beat for snfs_queue.
module snfs_front
    import snfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_mode,
    input  logic [7:0]  i_rx_byte,
    input  logic [23:0] i_chip_id,
    output logic        o_push,
    output t_op         o_op
);

    logic [7:0]  r_opcode, n_opcode;
    logic        r_present, n_present;
    logic [1:0]  r_addr_cnt, n_addr_cnt;
    logic [1:0]  r_id_idx, n_id_idx;
    logic [23:0] r_addr, n_addr;

    logic [23:0] addr_shift;
    logic [23:0] addr_inc;

    function automatic logic [7:0] id_byte(input logic [23:0] id, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = id[23:16];
            2'd1:    b = id[15:8];
            2'd2:    b = id[7:0];
            default: b = IDLE_BYTE;
        endcase
        return b;
    endfunction

    assign addr_shift = {r_addr[15:0], i_rx_byte};
    assign addr_inc   = r_addr + 24'd1;
    assign o_push     = i_accept;

    always_comb begin
        n_opcode   = r_opcode;
        n_present  = r_present;
        n_addr_cnt = r_addr_cnt;
        n_id_idx   = r_id_idx;
        n_addr     = r_addr;
        o_op.kind  = OP_KIND_CONST;
        o_op.addr  = r_addr;
        o_op.data  = IDLE_BYTE;

        if (!i_mode) begin
            // Chip select: drop the whole transaction.
            n_opcode   = 8'h00;
            n_present  = 1'b0;
            n_addr_cnt = 2'd0;
            n_id_idx   = 2'd0;
            n_addr     = 24'd0;
        end else if (!r_present) begin
            n_opcode   = i_rx_byte;
            n_present  = 1'b1;
            n_addr_cnt = 2'd0;
            n_id_idx   = 2'd0;
            n_addr     = 24'd0;
            unique case (i_rx_byte)
                OPC_READ_ID: begin
                    o_op.data = id_byte(i_chip_id, 2'd0);
                    n_id_idx  = 2'd1;
                end
                OPC_READ_STATUS: begin
                    o_op.data = STATUS_BYTE;
                end
                OPC_CHIP_ERASE: begin
                    o_op.kind = OP_KIND_ERASE;
                end
                default: ;
            endcase
        end else begin
            unique case (r_opcode)
                OPC_READ_ID: begin
                    if (r_id_idx != 2'd3) begin
                        o_op.data = id_byte(i_chip_id, r_id_idx);
                        n_id_idx  = r_id_idx + 2'd1;
                    end
                end
                OPC_READ_STATUS: begin
                    o_op.data = STATUS_BYTE;
                end
                OPC_READ: begin
                    if (r_addr_cnt != 2'd3) begin
                        n_addr_cnt = r_addr_cnt + 2'd1;
                        n_addr     = addr_shift;
                        if (r_addr_cnt == 2'd2) begin
                            // Third address byte already answers the first data byte.
                            o_op.kind = OP_KIND_READ;
                            o_op.addr = addr_shift;
                            n_addr    = addr_shift + 24'd1;
                        end
                    end else begin
                        o_op.kind = OP_KIND_READ;
                        n_addr    = addr_inc;
                    end
                end
                OPC_PAGE_PROGRAM: begin
                    if (r_addr_cnt != 2'd3) begin
                        n_addr_cnt = r_addr_cnt + 2'd1;
                        n_addr     = addr_shift;
                    end else begin
                        o_op.kind = OP_KIND_WRITE;
                        o_op.data = i_rx_byte;
                        n_addr    = addr_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode   <= 8'h00;
            r_present  <= 1'b0;
            r_addr_cnt <= 2'd0;
            r_id_idx   <= 2'd0;
            r_addr     <= 24'd0;
        end else if (i_accept) begin
            r_opcode   <= n_opcode;
            r_present  <= n_present;
            r_addr_cnt <= n_addr_cnt;
            r_id_idx   <= n_id_idx;
            r_addr     <= n_addr;
        end
    end

endmodule

// ----- sv/snfs_queue.sv -----
// Short first-in first-out queue of t_op entries between front and back end.
// Depends on snfs_pkg for the entry type and depth.
module snfs_queue
    import snfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op       i_op,
    input  logic      i_pop,
    output t_op       o_head,
    output t_q_status o_status
);

    t_op               r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_head         = r_entry[r_rptr];
    assign o_status.full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/snfs_back.sv -----
// Back end of the SPI NOR flash slave model: flash array, address reduction,
// clearing sweeps and the registered result beat. Depends on snfs_pkg.
module snfs_back
    import snfs_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_init_busy,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte
);

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int RECIP = (1 << 24) / MEM_BYTES;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = 24 + RW;

    localparam logic [RW-1:0] RECIP_C  = RW'(RECIP);
    localparam logic [24:0]   MEM_C    = 25'(MEM_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_BYTES - 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_QUO   = 3'd3;
    localparam logic [2:0] ST_RED   = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_RDAT  = 3'd6;
    localparam logic [2:0] ST_CLEAR = 3'd7;

    logic [7:0]    r_mem [MEM_BYTES];
    logic [7:0]    r_rdata;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_tx_valid, n_tx_valid;
    logic [7:0]    r_tx_byte, n_tx_byte;

    logic [1:0]    r_kind;
    logic [23:0]   r_addr;
    logic [7:0]    r_data;
    logic [PW-1:0] r_prod;
    logic [24:0]   r_qd;
    logic [AW-1:0] r_idx;

    logic [24:0]   rem_est;
    logic [24:0]   rem;
    logic          clearing;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    // Index = address mod MEM_BYTES: the estimated quotient is low by at most one.
    assign rem_est = {1'b0, r_addr} - r_qd;
    assign rem     = (rem_est >= MEM_C) ? (rem_est - MEM_C) : rem_est;

    assign mem_addr  = clearing ? r_clr_addr : r_idx;
    assign mem_wdata = clearing ? IDLE_BYTE : r_data;

    assign o_init_busy = (r_state == ST_INIT);
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_byte   = r_tx_byte;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_tx_valid = 1'b0;
        n_tx_byte  = r_tx_byte;
        o_pop      = 1'b0;
        clearing   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                clearing = 1'b1;
                mem_we   = 1'b1;
                if (r_clr_addr == LAST_IDX) begin
                    n_clr_addr = '0;
                    n_state    = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.kind) inside
                        OP_KIND_CONST: begin
                            n_tx_valid = 1'b1;
                            n_tx_byte  = i_head.data;
                        end
                        OP_KIND_ERASE: begin
                            n_clr_addr = '0;
                            n_state    = ST_CLEAR;
                        end
                        OP_KIND_READ, OP_KIND_WRITE: begin
                            n_state = ST_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL:  n_state = ST_QUO;
            ST_QUO:  n_state = ST_RED;
            ST_RED:  n_state = ST_ACC;
            ST_ACC: begin
                if (r_kind == OP_KIND_WRITE) begin
                    mem_we     = 1'b1;
                    n_tx_valid = 1'b1;
                    n_tx_byte  = IDLE_BYTE;
                    n_state    = ST_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_RDAT;
                end
            end
            ST_RDAT: begin
                n_tx_valid = 1'b1;
                n_tx_byte  = r_rdata;
                n_state    = ST_IDLE;
            end
            ST_CLEAR: begin
                clearing = 1'b1;
                mem_we   = 1'b1;
                if (r_clr_addr == LAST_IDX) begin
                    n_clr_addr = '0;
                    n_tx_valid = 1'b1;
                    n_tx_byte  = IDLE_BYTE;
                    n_state    = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_clr_addr <= '0;
            r_tx_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_tx_valid <= n_tx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_head.kind;
            r_addr <= i_head.addr;
            r_data <= i_head.data;
        end
        r_prod    <= PW'(r_addr) * PW'(RECIP_C);
        r_qd      <= 25'(r_prod[PW-1:24] * MEM_C);
        r_idx     <= AW'(rem);
        r_tx_byte <= n_tx_byte;
    end

endmodule

// ----- sv/spi_nor_flash_slave_model.sv -----
// A beat that needs no array access is answered straight from the queue; a program beat
// passes the MUL, QUO, RED and ACC states, a read beat also RDAT; a chip erase answers
// once the whole array is swept. The receiver cannot stall. Throughput: one beat per
// cycle from the queue for plain answers while the back end is idle; an array read or
// write holds the queue until its states are done. Reset (synchronous, i_rst_n low) clears
// the transaction state and sweeps the array to 0xFF, busy high.
module spi_nor_flash_slave_model
    import snfs_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel.
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [7:0]         i_rx_byte,
    // Result channel.
    output logic               o_tx_valid,
    output logic [7:0]         o_tx_byte,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // The ID register lives here; the front end reads it while decoding Read ID.
    logic [23:0] r_chip_id;

    logic        accept;
    logic        cfg_write;
    logic        push;
    t_op         push_op;
    t_op         head;
    t_q_status   q_status;
    logic        pop;
    logic        init_busy;

    // A beat is taken whenever the queue has room and the array is not being
    // swept after reset. A chip erase sweep only stalls the back end; the front
    // end keeps filling the queue until it is full.
    assign busy   = init_busy | q_status.full;
    assign accept = start & ~busy;

    // Configuration writes complete in the access phase; pready is tied high.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_id <= CHIP_ID_RESET;
        end else if (cfg_write && (paddr[PADDR_W-1] == CFG_IDX_CHIP_ID)) begin
            r_chip_id <= pwdata[23:0];
        end
    end

    // Reads return the ID in the low 24 bits while paddr[2] is clear, and zero otherwise.
    assign prdata = (paddr[PADDR_W-1] == CFG_IDX_CHIP_ID) ? {8'h00, r_chip_id} : 32'h0;

    // The front end decodes every beat into exactly one work entry, so results
    // leave the back end in the same order as the beats came in.
    snfs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_mode    (i_mode),
        .i_rx_byte (i_rx_byte),
        .i_chip_id (r_chip_id),
        .o_push    (push),
        .o_op      (push_op)
    );

    snfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (push_op),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // The back end owns the flash array: reads, program writes, erase and the
    // reset sweep all go through its single port.
    snfs_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_status.empty),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte)
    );

    `include "spi_nor_flash_slave_model_defines.svh"

    // No result may leave while the array is still being swept after reset.
    `SNFS_ASSERT_IMP(a_no_result_in_init, init_busy, !o_tx_valid, "result during reset sweep")

    // An accepted beat must be waiting in the queue in the next cycle.
    `SNFS_ASSERT_NXT(a_accept_fills_queue, accept, !q_status.empty, "accepted beat lost")

    // The queue can never report full and empty at once.
    `SNFS_ASSERT_IMP(a_queue_sane, q_status.full, !q_status.empty, "queue status corrupt")

endmodule
